### src/assert_macros.svh
// Assertion helpers; the clock is clk and the reset is rst_n in every user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)

`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### src/msn_pkg.sv
`default_nettype none

package msn_pkg;

    localparam int MAX_FRAME = 256;
    localparam int LEN_W     = 9;
    localparam int HDR_LEN   = 6;
    localparam int HDR_IDX_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME);

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCH_ENABLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCH_ADDRESS = 2'd2;

    localparam logic [15:0] GAP_RESET        = 16'd2005;
    localparam logic        WATCH_EN_RESET   = 1'b1;
    localparam logic [7:0]  WATCH_ADDR_RESET = 8'd11;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FC_READ_HOLD   = 8'h03;
    localparam logic [7:0] FC_READ_INPUT  = 8'h04;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI = 8'h10;

    localparam logic [2:0] KIND_OTHER     = 3'd0;
    localparam logic [2:0] KIND_READ_REQ  = 3'd1;
    localparam logic [2:0] KIND_READ_RSP  = 3'd2;
    localparam logic [2:0] KIND_WR_SINGLE = 3'd3;
    localparam logic [2:0] KIND_WRM_RSP   = 3'd4;
    localparam logic [2:0] KIND_WRM_REQ   = 3'd5;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [7:0]       hdr0;
        logic [7:0]       hdr1;
        logic [7:0]       hdr2;
        logic [7:0]       hdr3;
        logic [7:0]       hdr4;
        logic [7:0]       hdr5;
        logic             crc_zero;
    } frame_snap_t;

    typedef struct packed {
        logic [LEN_W-1:0] frame_length;
        logic             runt;
        logic [7:0]       slave_address;
        logic [7:0]       function_code;
        logic             is_exception;
        logic [7:0]       third_byte;
        logic [2:0]       frame_kind;
        logic [15:0]      first_word;
        logic [15:0]      second_word;
        logic             crc_ok;
        logic             watch_crc_bad;
    } frame_report_t;

    typedef struct packed {
        logic [15:0] gap_ticks;
        logic        watch_enable;
        logic [7:0]  watch_address;
    } cfg_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/msn_front.sv
`default_nettype none

module msn_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               acc,
    input  wire logic               operation,
    input  wire logic [7:0]         data_byte,
    input  wire logic [15:0]        gap_ticks,
    output logic                    push,
    output msn_pkg::frame_snap_t    snap
);
    import msn_pkg::*;

    `include "assert_macros.svh"

    logic [15:0]      crc_reg, crc_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      idle_reg, idle_next;
    logic [7:0]       hdr_reg [HDR_LEN];
    logic [7:0]       hdr_next [HDR_LEN];

    logic             open_w, close_tick, close_byte;
    logic [LEN_W-1:0] base_cnt;
    logic [15:0]      base_crc;

    assign open_w     = (cnt_reg != '0);
    assign close_tick = (operation == OP_TICK) && open_w && (idle_reg >= gap_ticks);
    assign close_byte = (operation == OP_BYTE) && open_w && (idle_reg > gap_ticks);
    assign push       = acc && (close_tick || close_byte);

    assign snap.len      = cnt_reg;
    assign snap.hdr0     = hdr_reg[0];
    assign snap.hdr1     = hdr_reg[1];
    assign snap.hdr2     = hdr_reg[2];
    assign snap.hdr3     = hdr_reg[3];
    assign snap.hdr4     = hdr_reg[4];
    assign snap.hdr5     = hdr_reg[5];
    assign snap.crc_zero = (crc_reg == '0);

    assign base_cnt = close_byte ? '0 : cnt_reg;
    assign base_crc = close_byte ? CRC_INIT : crc_reg;

    always_comb
    begin
        crc_next  = crc_reg;
        cnt_next  = cnt_reg;
        idle_next = idle_reg;
        for (int i = 0; i < HDR_LEN; i++)
        begin
            hdr_next[i] = hdr_reg[i];
        end
        if (acc)
        begin
            if (operation == OP_TICK)
            begin
                if (close_tick)
                begin
                    crc_next  = CRC_INIT;
                    cnt_next  = '0;
                    idle_next = '0;
                    for (int i = 0; i < HDR_LEN; i++)
                    begin
                        hdr_next[i] = '0;
                    end
                end
                else if (open_w)
                begin
                    idle_next = 16'(idle_reg + 16'd1);
                end
            end
            else
            begin
                if (close_byte)
                begin
                    for (int i = 0; i < HDR_LEN; i++)
                    begin
                        hdr_next[i] = '0;
                    end
                end
                if (base_cnt < LEN_W'(HDR_LEN))
                begin
                    hdr_next[base_cnt[HDR_IDX_W-1:0]] = data_byte;
                end
                cnt_next  = (base_cnt < MAX_LEN) ? LEN_W'(base_cnt + 1'b1) : base_cnt;
                crc_next  = crc_byte(base_crc, data_byte);
                idle_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= CRC_INIT;
            cnt_reg  <= '0;
            idle_reg <= '0;
            for (int i = 0; i < HDR_LEN; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else
        begin
            crc_reg  <= crc_next;
            cnt_reg  <= cnt_next;
            idle_reg <= idle_next;
            for (int i = 0; i < HDR_LEN; i++)
            begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

    `ASSERT_NEVER(a_idle_without_frame, (cnt_reg == '0) && (idle_reg != '0), "idle count with no frame open")
    `ASSERT_CLK(a_byte_opens_frame, acc && (operation == OP_BYTE) |=> (cnt_reg != '0) && (idle_reg == '0), "byte did not open frame")

endmodule

`default_nettype wire

### src/msn_queue.sv
`default_nettype none

module msn_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire msn_pkg::frame_snap_t wr_data,
    input  wire logic               pop,
    output msn_pkg::frame_snap_t    rd_data,
    output logic                    not_empty,
    output logic                    full
);
    import msn_pkg::*;

    `include "assert_macros.svh"

    frame_snap_t mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;

    assign not_empty = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
        end
    end

    `ASSERT_NEVER(a_push_full, push && full, "push into full report queue")

endmodule

`default_nettype wire

### src/msn_back.sv
`default_nettype none

module msn_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire msn_pkg::frame_snap_t snap,
    input  wire logic                 snap_valid,
    output logic                      pop,
    input  wire logic                 watch_enable,
    input  wire logic [7:0]           watch_address,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output msn_pkg::frame_report_t    report
);
    import msn_pkg::*;

    `include "assert_macros.svh"

    frame_report_t rpt_reg, rpt_next;
    logic          valid_reg;
    logic          runt_w, crc_ok_w, rd_fc, len8;
    logic [2:0]    kind_w;

    assign pop       = snap_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign report    = rpt_reg;

    assign runt_w   = (snap.len < LEN_W'(4));
    assign crc_ok_w = !runt_w && snap.crc_zero;
    assign rd_fc    = (snap.hdr1 == FC_READ_HOLD) || (snap.hdr1 == FC_READ_INPUT);
    assign len8     = (snap.len == LEN_W'(8));

    always_comb
    begin
        kind_w = KIND_OTHER;
        if (!runt_w && !snap.hdr1[7])
        begin
            if (rd_fc && len8)
            begin
                kind_w = KIND_READ_REQ;
            end
            else if (rd_fc && (snap.len >= LEN_W'(5))
                     && ({1'b0, snap.hdr2} == LEN_W'(snap.len - LEN_W'(5))))
            begin
                kind_w = KIND_READ_RSP;
            end
            else if ((snap.hdr1 == FC_WRITE_SINGLE) && len8)
            begin
                kind_w = KIND_WR_SINGLE;
            end
            else if ((snap.hdr1 == FC_WRITE_MULTI) && len8)
            begin
                kind_w = KIND_WRM_RSP;
            end
            else if ((snap.hdr1 == FC_WRITE_MULTI) && (snap.len > LEN_W'(8)))
            begin
                kind_w = KIND_WRM_REQ;
            end
        end
    end

    always_comb
    begin
        rpt_next.frame_length  = snap.len;
        rpt_next.runt          = runt_w;
        rpt_next.slave_address = snap.hdr0;
        rpt_next.function_code = snap.hdr1;
        rpt_next.is_exception  = snap.hdr1[7];
        rpt_next.third_byte    = snap.hdr2;
        rpt_next.frame_kind    = kind_w;
        rpt_next.first_word    = {snap.hdr2, snap.hdr3};
        rpt_next.second_word   = {snap.hdr4, snap.hdr5};
        rpt_next.crc_ok        = crc_ok_w;
        rpt_next.watch_crc_bad = !runt_w && watch_enable
                                 && (snap.hdr0 == watch_address) && !crc_ok_w;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rpt_reg <= rpt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    `ASSERT_NEVER(a_runt_clean, valid_reg && rpt_reg.runt && (rpt_reg.crc_ok || (rpt_reg.frame_kind != KIND_OTHER) || rpt_reg.watch_crc_bad), "runt report carries verdict")

endmodule

`default_nettype wire

### src/modbus_rtu_frame_sniffer_unit.sv
`default_nettype none

// Modbus RTU bus sniffer. Each input transaction is a received byte
// (operation 0) or one timebase tick (operation 1); one transaction is
// taken every cycle while in_ready is high. A frame closes on the first
// tick after its idle count has reached gap_ticks (or on a byte, if
// gap_ticks was lowered below the running idle count), and then one
// report comes out: length, header fields, kind code and CRC-16 verdict.
// The CRC byte update and frame bookkeeping are registered; closed frames
// pass through a two-entry queue to a decode stage whose registered
// output holds the report until taken. in_ready falls only while that
// queue is full, so a stalled output stops the input after two more
// frames close. Each closed frame is queued, then decoded and registered.
module modbus_rtu_frame_sniffer_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [msn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [msn_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         operation,
    input  wire logic [7:0]                   data_byte,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [msn_pkg::LEN_W-1:0]         frame_length,
    output logic                              runt,
    output logic [7:0]                        slave_address,
    output logic [7:0]                        function_code,
    output logic                              is_exception,
    output logic [7:0]                        third_byte,
    output logic [2:0]                        frame_kind,
    output logic [15:0]                       first_word,
    output logic [15:0]                       second_word,
    output logic                              crc_ok,
    output logic                              watch_crc_bad
);
    import msn_pkg::*;

    cfg_t          cfg_reg;
    frame_snap_t   snap_in, snap_out;
    frame_report_t rpt;
    logic          acc, push, pop, q_valid, q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_ticks     <= GAP_RESET;
            cfg_reg.watch_enable  <= WATCH_EN_RESET;
            cfg_reg.watch_address <= WATCH_ADDR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAP_TICKS:     cfg_reg.gap_ticks     <= cfg_data;
                CFG_WATCH_ENABLE:  cfg_reg.watch_enable  <= cfg_data[0];
                CFG_WATCH_ADDRESS: cfg_reg.watch_address <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    assign in_ready = !q_full;
    assign acc      = in_valid && in_ready;

    msn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .operation (operation),
        .data_byte (data_byte),
        .gap_ticks (cfg_reg.gap_ticks),
        .push      (push),
        .snap      (snap_in)
    );

    msn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (snap_in),
        .pop       (pop),
        .rd_data   (snap_out),
        .not_empty (q_valid),
        .full      (q_full)
    );

    msn_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .snap          (snap_out),
        .snap_valid    (q_valid),
        .pop           (pop),
        .watch_enable  (cfg_reg.watch_enable),
        .watch_address (cfg_reg.watch_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .report        (rpt)
    );

    assign frame_length  = rpt.frame_length;
    assign runt          = rpt.runt;
    assign slave_address = rpt.slave_address;
    assign function_code = rpt.function_code;
    assign is_exception  = rpt.is_exception;
    assign third_byte    = rpt.third_byte;
    assign frame_kind    = rpt.frame_kind;
    assign first_word    = rpt.first_word;
    assign second_word   = rpt.second_word;
    assign crc_ok        = rpt.crc_ok;
    assign watch_crc_bad = rpt.watch_crc_bad;

endmodule

`default_nettype wire
